// ===== hw/rtl/hslrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared types and constants for the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int HUE_W             = 9;
    localparam int CH_W              = 8;
    localparam int HUE_RANGE         = 360;
    // extra fraction bits of the 1/360 reciprocal; 2^17 > 359 * 360 keeps it exact
    localparam int HUE_SHIFT         = 17;
    localparam int NUM_CH            = 3;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  lightness;
    } hsl_pix_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_pix_t;

    // piecewise segment of the channel offset
    typedef enum logic [1:0] {
        RGN_RISE,
        RGN_HIGH,
        RGN_FALL,
        RGN_LOW
    } hue_rgn_t;

endpackage

// ===== hw/rtl/hslrgb_stream_if.sv =====
// ----------------------------------------------------------------------------
// hslrgb_stream_if
// Valid/ready stream carrying one pixel per beat.
// ----------------------------------------------------------------------------
interface hslrgb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hsl_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// Fixed-point HSL to RGB pixel converter, six register stages.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock unless back-pressure has filled all stages; its
// result passes through the stage registers and waits on the output until taken.
// Throughput is one pixel per clock, set by the six-stage pipeline whose
// deepest steps are the multiplies: the hue reciprocal and l*s products side
// by side in one stage, the per-channel slope products in a later one.
// Every stage has its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles close up under back-pressure and the input
// stays ready while a finished pixel waits on the output, until all six
// stages hold a beat. Hue of 360 or more is reduced modulo 360; zero
// saturation returns a grey equal to lightness.
module hsl_to_rgb_converter_core #(
    parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    hslrgb_stream_if.sink    hsl,
    hslrgb_stream_if.source  rgb
);
    import hslrgb_pkg::*;

    localparam int NSTG = 6;
    localparam int FW   = FRAC_BITS;
    localparam int HPW  = FW + HUE_SHIFT + 1;
    localparam int PW   = 2 * FW + 4;

    localparam longint unsigned HUE_RECIP_FULL =
        ((64'd1 << (FRAC_BITS + HUE_SHIFT)) + longint'(HUE_RANGE) - 64'd1) /
        longint'(HUE_RANGE);
    localparam logic [HPW-1:0] HUE_RECIP = HPW'(HUE_RECIP_FULL);
    localparam logic [FW:0]    ONE_FX    = (FW+1)'(64'd1 << FRAC_BITS);
    localparam logic [FW:0]    THIRD_FX  = (FW+1)'((64'd1 << FRAC_BITS) / 64'd3);
    localparam logic [FW:0]    TWO3_FX   = (FW+1)'((64'd2 << FRAC_BITS) / 64'd3);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || rgb.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= hsl.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign hsl.ready = en[0];
    assign rgb.valid = vld_reg[NSTG-1];

    // ---- stage 1: hue wrap ----
    logic [HUE_W-1:0] hue1_reg, hue1_next;
    logic [CH_W-1:0]  sat1_reg, lit1_reg;

    always_comb
    begin
        if (hsl.data.hue_deg >= HUE_W'(HUE_RANGE))
            hue1_next = hsl.data.hue_deg - HUE_W'(HUE_RANGE);
        else
            hue1_next = hsl.data.hue_deg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hue1_reg <= hue1_next;
            sat1_reg <= hsl.data.saturation;
            lit1_reg <= hsl.data.lightness;
        end
    end

    // ---- stage 2: h = hue/360 and l*s ----
    logic [FW-1:0]    h2_reg, h2_next;
    logic [FW-1:0]    ls2_reg, ls2_next;
    logic [CH_W-1:0]  sat2_reg, lit2_reg;
    logic             grey2_reg, grey2_next;
    logic [HPW-1:0]   hue_prod;
    logic [2*FW-1:0]  ls_prod;

    always_comb
    begin
        hue_prod   = HPW'(hue1_reg) * HUE_RECIP;
        h2_next    = hue_prod[HUE_SHIFT +: FW];
        ls_prod    = (2*FW)'({lit1_reg, {(FW-CH_W){1'b0}}}) *
                     (2*FW)'({sat1_reg, {(FW-CH_W){1'b0}}});
        ls2_next   = ls_prod[FW +: FW];
        grey2_next = (sat1_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h2_reg    <= h2_next;
            ls2_reg   <= ls2_next;
            sat2_reg  <= sat1_reg;
            lit2_reg  <= lit1_reg;
            grey2_reg <= grey2_next;
        end
    end

    // ---- stage 3: t1, t2 and channel offsets ----
    logic [FW:0]      t1_3_reg, t1_3_next;
    logic [FW:0]      t2_3_reg, t2_3_next;
    logic [FW:0]      t3_reg  [NUM_CH];
    logic [FW:0]      t3_next [NUM_CH];
    logic             grey3_reg;
    logic [CH_W-1:0]  lit3_reg;
    logic [FW:0]      l_fx, s_fx, ls_fx, h_fx, tr_sum;
    logic [FW+1:0]    l_dbl, t2_ext;

    always_comb
    begin
        l_fx  = (FW+1)'({lit2_reg, {(FW-CH_W){1'b0}}});
        s_fx  = (FW+1)'({sat2_reg, {(FW-CH_W){1'b0}}});
        ls_fx = (FW+1)'(ls2_reg);
        h_fx  = (FW+1)'(h2_reg);
        // lightness below one half iff its top bit is clear
        if (!lit2_reg[CH_W-1])
            t2_3_next = l_fx + ls_fx;
        else
            t2_3_next = l_fx + s_fx - ls_fx;
        l_dbl  = (FW+2)'(l_fx) << 1;
        t2_ext = (FW+2)'(t2_3_next);
        if (l_dbl >= t2_ext)
            t1_3_next = (FW+1)'(l_dbl - t2_ext);
        else
            t1_3_next = '0;
        tr_sum = h_fx + THIRD_FX;
        if (tr_sum > ONE_FX)
            t3_next[0] = tr_sum - ONE_FX;
        else
            t3_next[0] = tr_sum;
        t3_next[1] = h_fx;
        if (h_fx >= THIRD_FX)
            t3_next[2] = h_fx - THIRD_FX;
        else
            t3_next[2] = h_fx + ONE_FX - THIRD_FX;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t1_3_reg  <= t1_3_next;
            t2_3_reg  <= t2_3_next;
            t3_reg    <= t3_next;
            grey3_reg <= grey2_reg;
            lit3_reg  <= lit2_reg;
        end
    end

    // ---- stage 4: segment select and slope operand ----
    hue_rgn_t         rgn4_reg  [NUM_CH];
    hue_rgn_t         rgn4_next [NUM_CH];
    logic [FW+2:0]    op4_reg   [NUM_CH];
    logic [FW+2:0]    op4_next  [NUM_CH];
    logic [FW:0]      d4_reg, d4_next;
    logic [FW:0]      t1_4_reg, t2_4_reg;
    logic             grey4_reg;
    logic [CH_W-1:0]  lit4_reg;
    logic [FW+3:0]    t6 [NUM_CH];
    logic [FW+3:0]    f6 [NUM_CH];
    logic [FW+2:0]    t3x [NUM_CH];
    logic [FW+1:0]    t2x [NUM_CH];

    always_comb
    begin
        if (t2_3_reg >= t1_3_reg)
            d4_next = t2_3_reg - t1_3_reg;
        else
            d4_next = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            t2x[c] = (FW+2)'(t3_reg[c]) << 1;
            t3x[c] = ((FW+3)'(t3_reg[c]) << 1) + (FW+3)'(t3_reg[c]);
            t6[c]  = (FW+4)'(t3x[c]) << 1;
            f6[c]  = (FW+4)'(TWO3_FX - t3_reg[c]) * (FW+4)'(6);
            if (t6[c] < (FW+4)'(ONE_FX))
            begin
                rgn4_next[c] = RGN_RISE;
                op4_next[c]  = t6[c][FW+2:0];
            end
            else if (t2x[c] < (FW+2)'(ONE_FX))
            begin
                rgn4_next[c] = RGN_HIGH;
                op4_next[c]  = '0;
            end
            else if (t3x[c] < ((FW+3)'(ONE_FX) << 1))
            begin
                rgn4_next[c] = RGN_FALL;
                op4_next[c]  = f6[c][FW+2:0];
            end
            else
            begin
                rgn4_next[c] = RGN_LOW;
                op4_next[c]  = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rgn4_reg  <= rgn4_next;
            op4_reg   <= op4_next;
            d4_reg    <= d4_next;
            t1_4_reg  <= t1_3_reg;
            t2_4_reg  <= t2_3_reg;
            grey4_reg <= grey3_reg;
            lit4_reg  <= lit3_reg;
        end
    end

    // ---- stage 5: slope multiply ----
    hue_rgn_t         rgn5_reg  [NUM_CH];
    logic [FW+3:0]    inc5_reg  [NUM_CH];
    logic [FW+3:0]    inc5_next [NUM_CH];
    logic [FW:0]      t1_5_reg, t2_5_reg;
    logic             grey5_reg;
    logic [CH_W-1:0]  lit5_reg;
    logic [PW-1:0]    slope_prod [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            slope_prod[c] = PW'(d4_reg) * PW'(op4_reg[c]);
            inc5_next[c]  = slope_prod[c][FW +: FW+4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            rgn5_reg  <= rgn4_reg;
            inc5_reg  <= inc5_next;
            t1_5_reg  <= t1_4_reg;
            t2_5_reg  <= t2_4_reg;
            grey5_reg <= grey4_reg;
            lit5_reg  <= lit4_reg;
        end
    end

    // ---- stage 6: channel value, scale and saturate ----
    rgb_pix_t         rgb6_reg, rgb6_next;
    logic [FW+4:0]    chv  [NUM_CH];
    logic [12:0]      chhi [NUM_CH];
    logic [CH_W-1:0]  chb  [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            case (rgn5_reg[c])
                RGN_HIGH: chv[c] = (FW+5)'(t2_5_reg);
                RGN_LOW:  chv[c] = (FW+5)'(t1_5_reg);
                default:  chv[c] = (FW+5)'(t1_5_reg) + (FW+5)'(inc5_reg[c]);
            endcase
            chhi[c] = chv[c][FW+4:FW-CH_W];
            if (chhi[c] > 13'd255)
                chb[c] = '1;
            else
                chb[c] = chhi[c][CH_W-1:0];
        end
        if (grey5_reg)
        begin
            rgb6_next.red   = lit5_reg;
            rgb6_next.green = lit5_reg;
            rgb6_next.blue  = lit5_reg;
        end
        else
        begin
            rgb6_next.red   = chb[0];
            rgb6_next.green = chb[1];
            rgb6_next.blue  = chb[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            rgb6_reg <= rgb6_next;
        end
    end

    assign rgb.data = rgb6_reg;

    // t2 never falls below t1 for in-range fractions
    a_t1_le_t2: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (t1_3_reg <= t2_3_reg))
        else $error("t1 above t2");

    // flat segments carry no slope term into the multiplier
    a_flat_no_slope: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && (rgn4_reg[0] == RGN_HIGH || rgn4_reg[0] == RGN_LOW)
        |-> (op4_reg[0] == '0))
        else $error("slope operand on flat segment");

    // an empty output stage always lets a new pixel in
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NSTG-1] |-> hsl.ready)
        else $error("input stalled with empty output");

    // a stalled stage keeps its beat
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && !en[2] |=> vld_reg[2])
        else $error("beat lost in stalled stage");

endmodule
